// ----- rtl/swl_pkg.sv -----
`default_nettype none
package swl_pkg;

   localparam int MAX_SAMPLES = 16;
   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int SLOT_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SC_W        = 5;
   localparam int EXT_W       = (CNT_W > SC_W) ? CNT_W : SC_W;
   localparam int PROD_W      = 2 * DATA_W - 1;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_RECIPROCAL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABILITY_TOLERANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STABILITY_TIME_MS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_THRESHOLD     = 3'd4;

   // register reset values
   localparam logic [DATA_W-1:0] RST_SCALE_RECIPROCAL    = 32'd65536;
   localparam logic [DATA_W-1:0] RST_STABILITY_TOLERANCE = 32'd6554;
   localparam logic [SC_W-1:0]   RST_SAMPLE_COUNT        = 5'd10;
   localparam logic [DATA_W-1:0] RST_STABILITY_TIME_MS   = 32'd1000;
   localparam logic [DATA_W-1:0] RST_RESET_THRESHOLD     = 32'd32768;

   typedef struct packed {
      logic              clear;
      logic              we;
      logic [SLOT_W-1:0] waddr;
      logic [SLOT_W-1:0] raddr;
   } ram_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/swl_if.sv -----
`default_nettype none
interface swl_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] reading;
   logic [31:0]        now_ms;

   modport source (output valid, command, reading, now_ms, input ready);
   modport sink (input valid, command, reading, now_ms, output ready);
endinterface

interface swl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] weight;
   logic        locked;
   logic        stable;

   modport source (output valid, weight, locked, stable, input ready);
   modport sink (input valid, weight, locked, stable, output ready);
endinterface
`default_nettype wire

// ----- rtl/stable_weight_lock.sv -----
// sequence: a process request is multiplied, written to the ring, and the n ring entries
//    in use (1..16) are walked before decide (early exit on an unstable entry); a clear
//    request goes straight to decide; decide waits while an earlier result is not taken
// a new request is taken only in idle; the ring walk reads one entry per cycle, no stall
// reset: synchronous, clears lock, timing, write slot and ring valid bits at once;
//    no clearing pass, the ring reads as zero until written
`default_nettype none
module stable_weight_lock (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   swl_req_if.sink                                   req_chan,
   swl_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_wr_en,
   input  wire logic [swl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [swl_pkg::DATA_W-1:0]           csr_wr_data
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_MUL    = 3'd1;
   localparam logic [ST_W-1:0] ST_WRITE  = 3'd2;
   localparam logic [ST_W-1:0] ST_FIRST  = 3'd3;
   localparam logic [ST_W-1:0] ST_LOADF  = 3'd4;
   localparam logic [ST_W-1:0] ST_SCAN   = 3'd5;
   localparam logic [ST_W-1:0] ST_DECIDE = 3'd6;

   localparam int DW = swl_pkg::DATA_W;
   localparam int SW = swl_pkg::SLOT_W;
   localparam int CW = swl_pkg::CNT_W;
   localparam int EW = swl_pkg::EXT_W;

   // configuration registers
   logic [DW-1:0]            scale_ff, tol_ff, time_ff, thr_ff;
   logic [swl_pkg::SC_W-1:0] count_ff;

   // control state
   logic [ST_W-1:0] state_ff, state_in;
   logic [SW-1:0]   slot_ff, slot_in;
   logic [SW-1:0]   rd_addr_ff, rd_addr_in;
   logic            lock_ff, lock_in;
   logic            timing_ff, timing_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // item payload
   logic                 cmd_ff;
   logic signed [DW-1:0] reading_ff;
   logic [DW-1:0]        now_ff;
   logic [DW-1:0]        w_ff;
   logic [DW-1:0]        first_ff;
   logic                 stable_ff;
   logic [DW-1:0]        held_ff, held_in;
   logic [DW-1:0]        start_ff, start_in;
   logic [DW-1:0]        rsp_weight_ff, rsp_weight_in;
   logic                 rsp_locked_ff, rsp_locked_in;
   logic                 rsp_stable_ff, rsp_stable_in;

   logic                  accept, out_free, cfg_count_wr;
   logic [DW-1:0]         w_now, rd_data, diff, elapsed;
   logic [EW-1:0]         count_ext, n_ext;
   logic [CW-1:0]         n, slot_use, slot_next;
   logic                  over_tol, last_entry;
   swl_pkg::ram_ctrl_type ram_ctrl;

   assign accept       = req_chan.valid && req_chan.ready;
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign cfg_count_wr = csr_wr_en && (csr_index == swl_pkg::CSR_SAMPLE_COUNT);

   // entries in use: zero acts as one, clipped to ring depth
   assign count_ext = EW'(count_ff);
   always_comb begin
      if (count_ext == '0) begin
         n_ext = EW'(1);
      end else if (count_ext > EW'(swl_pkg::MAX_SAMPLES)) begin
         n_ext = EW'(swl_pkg::MAX_SAMPLES);
      end else begin
         n_ext = count_ext;
      end
   end
   assign n = CW'(n_ext);

   // ring slot for this sample and the one after
   assign slot_use   = (CW'(slot_ff) >= n) ? '0 : CW'(slot_ff);
   assign slot_next  = (slot_use + CW'(1) >= n) ? '0 : slot_use + CW'(1);
   assign last_entry = (rd_addr_ff == SW'(n - CW'(1)));

   // absolute distance from slot zero
   assign diff     = (rd_data > first_ff) ? rd_data - first_ff : first_ff - rd_data;
   assign over_tol = diff > tol_ff;
   assign elapsed  = now_ff - start_ff;

   swl_weight_mul u_mul (
      .clock   (clock),
      .reading (reading_ff),
      .scale   (scale_ff),
      .weight  (w_now)
   );

   assign ram_ctrl.clear = cfg_count_wr;
   assign ram_ctrl.we    = (state_ff == ST_WRITE);
   assign ram_ctrl.waddr = SW'(slot_use);
   assign ram_ctrl.raddr = rd_addr_in;

   swl_ring_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ram_ctrl),
      .wr_data (w_now),
      .rd_data (rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= swl_pkg::RST_SCALE_RECIPROCAL;
         tol_ff   <= swl_pkg::RST_STABILITY_TOLERANCE;
         count_ff <= swl_pkg::RST_SAMPLE_COUNT;
         time_ff  <= swl_pkg::RST_STABILITY_TIME_MS;
         thr_ff   <= swl_pkg::RST_RESET_THRESHOLD;
      end else if (csr_wr_en) begin
         case (csr_index)
            swl_pkg::CSR_SCALE_RECIPROCAL: begin
               scale_ff <= csr_wr_data;
            end
            swl_pkg::CSR_STABILITY_TOLERANCE: begin
               tol_ff <= csr_wr_data;
            end
            swl_pkg::CSR_SAMPLE_COUNT: begin
               count_ff <= csr_wr_data[swl_pkg::SC_W-1:0];
            end
            swl_pkg::CSR_STABILITY_TIME_MS: begin
               time_ff <= csr_wr_data;
            end
            swl_pkg::CSR_RESET_THRESHOLD: begin
               thr_ff <= csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: multiply, write ring, walk ring, decide lock; a clear command goes straight to decide
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      rd_addr_in    = rd_addr_ff;
      lock_in       = lock_ff;
      timing_in     = timing_ff;
      held_in       = held_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_weight_in = rsp_weight_ff;
      rsp_locked_in = rsp_locked_ff;
      rsp_stable_in = rsp_stable_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_chan.command ? ST_DECIDE : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            slot_in  = SW'(slot_next);
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            rd_addr_in = '0;
            state_in   = ST_LOADF;
         end
         ST_LOADF: begin
            // slot zero arrives; start reading slot one
            rd_addr_in = SW'(1);
            state_in   = (n == CW'(1)) ? ST_DECIDE : ST_SCAN;
         end
         ST_SCAN: begin
            if (over_tol || last_entry) begin
               state_in = ST_DECIDE;
            end else begin
               rd_addr_in = rd_addr_ff + SW'(1);
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (cmd_ff) begin
                  lock_in       = 1'b0;
                  held_in       = '0;
                  timing_in     = 1'b0;
                  rsp_weight_in = '0;
                  rsp_locked_in = 1'b0;
                  rsp_stable_in = 1'b0;
               end else begin
                  if (w_ff < thr_ff) begin
                     lock_in = 1'b0;
                     held_in = '0;
                  end else if (stable_ff && !lock_ff) begin
                     if (!timing_ff) begin
                        timing_in = 1'b1;
                        start_in  = now_ff;
                     end else if (elapsed > time_ff) begin
                        lock_in = 1'b1;
                        held_in = w_ff;
                     end
                  end else if (!stable_ff) begin
                     timing_in = 1'b0;
                  end
                  rsp_weight_in = lock_in ? held_in : w_ff;
                  rsp_locked_in = lock_in;
                  rsp_stable_in = stable_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cfg_count_wr) begin
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         rd_addr_ff   <= '0;
         lock_ff      <= 1'b0;
         timing_ff    <= 1'b0;
         held_ff      <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rd_addr_ff   <= rd_addr_in;
         lock_ff      <= lock_in;
         timing_ff    <= timing_in;
         held_ff      <= held_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_chan.command;
         reading_ff <= req_chan.reading;
         now_ff     <= req_chan.now_ms;
      end
      if (state_ff == ST_WRITE) begin
         w_ff <= w_now;
      end
      if (state_ff == ST_LOADF) begin
         first_ff  <= rd_data;
         stable_ff <= 1'b1;
      end
      if (state_ff == ST_SCAN && over_tol) begin
         stable_ff <= 1'b0;
      end
      rsp_weight_ff <= rsp_weight_in;
      rsp_locked_ff <= rsp_locked_in;
      rsp_stable_ff <= rsp_stable_in;
   end

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.weight = rsp_weight_ff;
   assign rsp_chan.locked = rsp_locked_ff;
   assign rsp_chan.stable = rsp_stable_ff;

   // a result only appears out of the decide step
   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
      else $error("result raised outside decide step");

   // ring walk stays inside the entries in use
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(rd_addr_ff) < n))
      else $error("ring walk beyond entries in use");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not leave idle");

endmodule
`default_nettype wire

// ----- rtl/swl_ring_ram.sv -----
`default_nettype none
module swl_ring_ram (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire swl_pkg::ram_ctrl_type       ctrl,
   input  wire logic [swl_pkg::DATA_W-1:0]  wr_data,
   output logic      [swl_pkg::DATA_W-1:0]  rd_data
);

   logic [swl_pkg::DATA_W-1:0]      mem [swl_pkg::MAX_SAMPLES];
   logic [swl_pkg::MAX_SAMPLES-1:0] valid_ff;
   logic [swl_pkg::DATA_W-1:0]      rd_data_ff;
   logic                            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[ctrl.waddr] <= wr_data;
      end
      rd_data_ff <= mem[ctrl.raddr];
   end

   // entries never written since reset or clear read as zero
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctrl.we) begin
            valid_ff[ctrl.waddr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[ctrl.raddr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ----- rtl/swl_weight_mul.sv -----
`default_nettype none
module swl_weight_mul (
   input  wire logic                              clock,
   input  wire logic signed [swl_pkg::DATA_W-1:0] reading,
   input  wire logic        [swl_pkg::DATA_W-1:0] scale,
   output logic             [swl_pkg::DATA_W-1:0] weight
);

   logic [swl_pkg::DATA_W-2:0] mag;
   logic [swl_pkg::PROD_W-1:0] prod_ff;

   // negative readings clamp to zero
   assign mag = reading[swl_pkg::DATA_W-1] ? '0 : reading[swl_pkg::DATA_W-2:0];

   always_ff @(posedge clock) begin
      prod_ff <= swl_pkg::PROD_W'(mag) * swl_pkg::PROD_W'(scale);
   end

   // drop fraction bits, saturate on overflow
   assign weight = (|prod_ff[swl_pkg::PROD_W-1:swl_pkg::DATA_W+swl_pkg::FRAC_W])
                   ? '1 : prod_ff[swl_pkg::DATA_W+swl_pkg::FRAC_W-1:swl_pkg::FRAC_W];

endmodule
`default_nettype wire
